>>> sv/stvg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the stroke text vertex generator.
package stvg_pkg;

  localparam int CoordW = 32;
  localparam int WidthW = 16;
  localparam int CfgW   = 16;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // shared multiplier operands and result
  localparam int MulAW = 50;
  localparam int MulBW = 17;
  localparam int ProdW = MulAW + MulBW;
  // rotated or scaled offset, and offset plus pen
  localparam int VecW  = 54;
  localparam int SumW  = VecW + 2;

  localparam int FqDepth = 2;
  localparam int FqAw    = $clog2(FqDepth);

  // input opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_POINT   = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // precision modes; codes above char precision act as stroke precision
  localparam logic [1:0] MODE_STRING = 2'd0;
  localparam logic [1:0] MODE_CHAR   = 2'd1;

  // register indexes
  localparam logic [2:0] REG_CHAR_HEIGHT    = 3'd0;
  localparam logic [2:0] REG_CHAR_EXPANSION = 3'd1;
  localparam logic [2:0] REG_CHAR_SPACING   = 3'd2;
  localparam logic [2:0] REG_UP_VECTOR_X    = 3'd3;
  localparam logic [2:0] REG_UP_VECTOR_Y    = 3'd4;
  localparam logic [2:0] REG_PATH_DIRECTION = 3'd5;
  localparam logic [2:0] REG_PRECISION_MODE = 3'd6;
  localparam logic [2:0] REG_FONT_HEIGHT    = 3'd7;

  localparam logic [CfgW-1:0] RST_CHAR_HEIGHT    = 16'd256;
  localparam logic [CfgW-1:0] RST_CHAR_EXPANSION = 16'd256;
  localparam logic [CfgW-1:0] RST_CHAR_SPACING   = 16'd0;
  localparam logic [CfgW-1:0] RST_UP_VECTOR_X    = 16'd0;
  localparam logic [CfgW-1:0] RST_UP_VECTOR_Y    = 16'd16384;
  localparam logic [1:0]      RST_PATH_DIRECTION = 2'd0;
  localparam logic [1:0]      RST_PRECISION_MODE = 2'd2;
  localparam logic [CfgW-1:0] RST_FONT_HEIGHT    = 16'd256;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_POINT,
    KIND_ADVANCE
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [CoordW-1:0]  coord_x;
    logic signed [CoordW-1:0]  coord_y;
    logic                      strip_begin;
    logic signed [WidthW-1:0]  advance_width;
  } fq_entry_t;

  typedef struct packed {
    logic [CfgW-1:0]        char_height;
    logic [CfgW-1:0]        char_expansion;
    logic signed [CfgW-1:0] char_spacing;
    logic signed [CfgW-1:0] up_vector_x;
    logic signed [CfgW-1:0] up_vector_y;
    logic [1:0]             path_direction;
    logic [1:0]             precision_mode;
    logic [CfgW-1:0]        font_height;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_XH,
    ST_P_XE,
    ST_P_YH,
    ST_P_XUY,
    ST_P_YUX,
    ST_P_YUY,
    ST_P_XUX,
    ST_A_WH,
    ST_A_E,
    ST_A_VH,
    ST_A_DU1,
    ST_A_DU2,
    ST_FIN
  } bk_state_t;

  typedef struct packed {
    logic                     flag;
    logic signed [CoordW-1:0] value;
  } sat_t;

  localparam logic signed [SumW-1:0] SatHi = SumW'(2147483647);
  localparam logic signed [SumW-1:0] SatLo = ~SatHi;

  function automatic sat_t sat_coord(input logic signed [SumW-1:0] v);
    sat_t r;
    r.flag  = 1'b0;
    r.value = v[CoordW-1:0];
    if (v > SatHi) begin
      r.flag  = 1'b1;
      r.value = SatHi[CoordW-1:0];
    end else if (v < SatLo) begin
      r.flag  = 1'b1;
      r.value = SatLo[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/stvg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file.
module stvg_regs
  import stvg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CHAR_HEIGHT:    cfg_nxt.char_height    = pwdata[CfgW-1:0];
        REG_CHAR_EXPANSION: cfg_nxt.char_expansion = pwdata[CfgW-1:0];
        REG_CHAR_SPACING:   cfg_nxt.char_spacing   = pwdata[CfgW-1:0];
        REG_UP_VECTOR_X:    cfg_nxt.up_vector_x    = pwdata[CfgW-1:0];
        REG_UP_VECTOR_Y:    cfg_nxt.up_vector_y    = pwdata[CfgW-1:0];
        REG_PATH_DIRECTION: cfg_nxt.path_direction = pwdata[1:0];
        REG_PRECISION_MODE: cfg_nxt.precision_mode = pwdata[1:0];
        REG_FONT_HEIGHT:    cfg_nxt.font_height    = pwdata[CfgW-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHAR_HEIGHT:    prdata = DataW'(cfg_r.char_height);
      REG_CHAR_EXPANSION: prdata = DataW'(cfg_r.char_expansion);
      REG_CHAR_SPACING:   prdata = DataW'($unsigned(cfg_r.char_spacing));
      REG_UP_VECTOR_X:    prdata = DataW'($unsigned(cfg_r.up_vector_x));
      REG_UP_VECTOR_Y:    prdata = DataW'($unsigned(cfg_r.up_vector_y));
      REG_PATH_DIRECTION: prdata = DataW'(cfg_r.path_direction);
      REG_PRECISION_MODE: prdata = DataW'(cfg_r.precision_mode);
      REG_FONT_HEIGHT:    prdata = DataW'(cfg_r.font_height);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.char_height    <= RST_CHAR_HEIGHT;
      cfg_r.char_expansion <= RST_CHAR_EXPANSION;
      cfg_r.char_spacing   <= RST_CHAR_SPACING;
      cfg_r.up_vector_x    <= RST_UP_VECTOR_X;
      cfg_r.up_vector_y    <= RST_UP_VECTOR_Y;
      cfg_r.path_direction <= RST_PATH_DIRECTION;
      cfg_r.precision_mode <= RST_PRECISION_MODE;
      cfg_r.font_height    <= RST_FONT_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/stvg_front.sv
`timescale 1ns / 1ps
// Input stage: accepts items, decodes the opcode and queues them for the back end.
module stvg_front
  import stvg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [CoordW-1:0] in_coord_x,
  input  logic signed [CoordW-1:0] in_coord_y,
  input  logic                     in_strip_begin,
  input  logic signed [WidthW-1:0] in_advance_width,
  output logic                     q_valid,
  output fq_entry_t                q_entry,
  input  logic                     q_pop
);

  fq_entry_t        fq_mem_r [FqDepth];
  logic [FqAw-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FqAw-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FqAw:0]    cnt_r, cnt_nxt;
  fq_entry_t        entry;
  logic             entry_ok;
  logic             push;

  always_comb begin
    entry.coord_x       = in_coord_x;
    entry.coord_y       = in_coord_y;
    entry.strip_begin   = in_strip_begin;
    entry.advance_width = in_advance_width;
    entry_ok            = 1'b1;
    unique case (in_opcode)
      OP_START:   entry.kind = KIND_START;
      OP_POINT:   entry.kind = KIND_POINT;
      OP_ADVANCE: entry.kind = KIND_ADVANCE;
      default: begin
        // unused opcode: taken and dropped
        entry.kind = KIND_START;
        entry_ok   = 1'b0;
      end
    endcase
  end

  assign in_ready = (cnt_r != (FqAw+1)'(FqDepth));
  assign push     = in_valid & in_ready & entry_ok;
  assign q_valid  = (cnt_r != '0);
  assign q_entry  = fq_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (FqAw+1)'(push) - (FqAw+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq_mem_r[wr_ptr_r] <= entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("queue popped while empty");

endmodule

>>> sv/stvg_back.sv
`timescale 1ns / 1ps
// Execution sequencer: shared multiplier, pen registers and result register.
module stvg_back
  import stvg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  fq_entry_t                q_entry,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] out_vertex_x,
  output logic signed [CoordW-1:0] out_vertex_y,
  output logic                     out_strip_start,
  output logic                     out_saturated
);

  localparam logic signed [ProdW-1:0] Half8   = ProdW'(128);
  localparam logic signed [ProdW-1:0] Half14  = ProdW'(8192);
  localparam logic signed [ProdW:0]   Half14w = (ProdW+1)'(8192);

  bk_state_t                state_r, state_nxt;
  fq_entry_t                item_r, item_nxt;
  logic signed [MulAW-1:0]  t_r, t_nxt;
  logic signed [MulAW-1:0]  fx_r, fx_nxt;
  logic signed [MulAW-1:0]  fy_r, fy_nxt;
  logic signed [ProdW-1:0]  acc_r, acc_nxt;
  logic signed [VecW-1:0]   vx_r, vx_nxt;
  logic signed [VecW-1:0]   vy_r, vy_nxt;
  logic signed [CoordW-1:0] pen_x_r, pen_x_nxt;
  logic signed [CoordW-1:0] pen_y_r, pen_y_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CoordW-1:0] out_x_r, out_x_nxt;
  logic signed [CoordW-1:0] out_y_r, out_y_nxt;
  logic                     out_strip_r, out_strip_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod, prod_r8, prod_r14;
  logic signed [ProdW:0]    acc_sum, acc_diff;
  logic signed [MulBW-1:0]  h17, e17, ux17, uy17, nux17;
  logic signed [16:0]       ws;
  logic signed [17:0]       fs;
  logic                     is_string, is_stroke, neg;
  logic signed [SumW-1:0]   dx, dy;
  sat_t                     sat_x, sat_y;

  assign h17   = $signed({1'b0, cfg.char_height});
  assign e17   = $signed({1'b0, cfg.char_expansion});
  assign ux17  = MulBW'($signed(cfg.up_vector_x));
  assign uy17  = MulBW'($signed(cfg.up_vector_y));
  assign nux17 = -ux17;
  assign ws    = 17'($signed(item_r.advance_width)) + 17'($signed(cfg.char_spacing));
  assign fs    = $signed({2'b00, cfg.font_height}) + 18'($signed(cfg.char_spacing));

  assign is_string = (cfg.precision_mode == MODE_STRING);
  assign is_stroke = cfg.precision_mode[1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_P_XH:  begin mul_a = MulAW'($signed(item_r.coord_x)); mul_b = h17; end
      ST_P_XE:  begin mul_a = t_r;  mul_b = e17;  end
      ST_P_YH:  begin mul_a = MulAW'($signed(item_r.coord_y)); mul_b = h17; end
      ST_P_XUY: begin mul_a = fx_r; mul_b = uy17; end
      ST_P_YUX: begin mul_a = fy_r; mul_b = ux17; end
      ST_P_YUY: begin mul_a = fy_r; mul_b = uy17; end
      ST_P_XUX: begin mul_a = fx_r; mul_b = ux17; end
      ST_A_WH: begin
        mul_a = is_string ? MulAW'($signed(item_r.advance_width)) : MulAW'(ws);
        mul_b = h17;
      end
      ST_A_E:   begin mul_a = t_r; mul_b = e17; end
      ST_A_VH:  begin mul_a = MulAW'(fs); mul_b = h17; end
      ST_A_DU1: begin mul_a = t_r; mul_b = cfg.path_direction[1] ? ux17 : uy17;  end
      ST_A_DU2: begin mul_a = t_r; mul_b = cfg.path_direction[1] ? uy17 : nux17; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_r8  = (prod + Half8) >>> 8;
  assign prod_r14 = (prod + Half14) >>> 14;
  assign acc_sum  = ((ProdW+1)'(acc_r) + (ProdW+1)'(prod) + Half14w) >>> 14;
  assign acc_diff = ((ProdW+1)'(acc_r) - (ProdW+1)'(prod) + Half14w) >>> 14;

  // left and down paths move the pen backward, except in string precision
  assign neg   = (item_r.kind == KIND_ADVANCE) && !is_string && cfg.path_direction[0];
  assign dx    = neg ? -SumW'(vx_r) : SumW'(vx_r);
  assign dy    = neg ? -SumW'(vy_r) : SumW'(vy_r);
  assign sat_x = sat_coord(SumW'(pen_x_r) + dx);
  assign sat_y = sat_coord(SumW'(pen_y_r) + dy);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    t_nxt         = t_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    acc_nxt       = acc_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_strip_nxt = out_strip_r;
    out_sat_nxt   = out_sat_r;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_entry;
          unique case (q_entry.kind)
            KIND_START: state_nxt = ST_FIN;
            KIND_POINT: state_nxt = ST_P_XH;
            KIND_ADVANCE: begin
              if (!is_string && cfg.path_direction[1]) begin
                state_nxt = ST_A_VH;
              end else begin
                state_nxt = ST_A_WH;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_P_XH: begin
        t_nxt     = prod_r8[MulAW-1:0];
        state_nxt = ST_P_XE;
      end
      ST_P_XE: begin
        fx_nxt    = prod_r8[MulAW-1:0];
        state_nxt = ST_P_YH;
      end
      ST_P_YH: begin
        fy_nxt = prod_r8[MulAW-1:0];
        if (is_stroke) begin
          state_nxt = ST_P_XUY;
        end else begin
          vx_nxt    = VecW'(fx_r);
          vy_nxt    = prod_r8[VecW-1:0];
          state_nxt = ST_FIN;
        end
      end
      ST_P_XUY: begin
        acc_nxt   = prod;
        state_nxt = ST_P_YUX;
      end
      ST_P_YUX: begin
        vx_nxt    = acc_sum[VecW-1:0];
        state_nxt = ST_P_YUY;
      end
      ST_P_YUY: begin
        acc_nxt   = prod;
        state_nxt = ST_P_XUX;
      end
      ST_P_XUX: begin
        vy_nxt    = acc_diff[VecW-1:0];
        state_nxt = ST_FIN;
      end
      ST_A_WH: begin
        t_nxt     = prod[MulAW-1:0];
        state_nxt = ST_A_E;
      end
      ST_A_E: begin
        if (is_stroke) begin
          t_nxt     = prod_r8[MulAW-1:0];
          state_nxt = ST_A_DU1;
        end else begin
          vx_nxt    = prod_r8[VecW-1:0];
          vy_nxt    = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_A_VH: begin
        if (is_stroke) begin
          t_nxt     = prod[MulAW-1:0];
          state_nxt = ST_A_DU1;
        end else begin
          vx_nxt    = '0;
          vy_nxt    = prod[VecW-1:0];
          state_nxt = ST_FIN;
        end
      end
      ST_A_DU1: begin
        vx_nxt    = prod_r14[VecW-1:0];
        state_nxt = ST_A_DU2;
      end
      ST_A_DU2: begin
        vy_nxt    = prod_r14[VecW-1:0];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        unique case (item_r.kind)
          KIND_START: begin
            pen_x_nxt = item_r.coord_x;
            pen_y_nxt = item_r.coord_y;
            state_nxt = ST_IDLE;
          end
          KIND_POINT: begin
            if (!out_valid_r || out_ready) begin
              out_valid_nxt = 1'b1;
              out_x_nxt     = sat_x.value;
              out_y_nxt     = sat_y.value;
              out_strip_nxt = item_r.strip_begin;
              out_sat_nxt   = sat_x.flag | sat_y.flag;
              state_nxt     = ST_IDLE;
            end
          end
          KIND_ADVANCE: begin
            pen_x_nxt = sat_x.value;
            pen_y_nxt = sat_y.value;
            state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    t_r         <= t_nxt;
    fx_r        <= fx_nxt;
    fy_r        <= fy_nxt;
    acc_r       <= acc_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_strip_r <= out_strip_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_vertex_x    = out_x_r;
  assign out_vertex_y    = out_y_r;
  assign out_strip_start = out_strip_r;
  assign out_saturated   = out_sat_r;

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish step");

  a_pen_only_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_FIN |=> $stable(pen_x_r) && $stable(pen_y_r))
    else $error("pen moved outside the finish step");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |->
      out_x_r == SatHi[CoordW-1:0] || out_x_r == SatLo[CoordW-1:0] ||
      out_y_r == SatHi[CoordW-1:0] || out_y_r == SatLo[CoordW-1:0])
    else $error("saturation flag without a clamped coordinate");

endmodule

>>> sv/stroke_text_vertex_generator_core.sv
`timescale 1ns / 1ps
// Top level of the stroke text vertex generator.
//
//   channel   ports          transfer when
//   input     in_*           in_valid & in_ready
//   result    out_*          out_valid & out_ready
//   config    psel/penable   psel & penable & pwrite (pready tied high)
//
// Items pass a two-entry queue to a sequencer built around one 50x17 multiplier.
// Start skips to finish; point and advance use the multiplier, rotating in stroke.
// Throughput is set by the multiplier steps of the sequencer, one item at a time.
// rst_n is synchronous; it clears the pen, the queue and the result valid.
// The queue takes items while the sequencer waits on a held result.
module stroke_text_vertex_generator_core
  import stvg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [CoordW-1:0] in_coord_x,
  input  logic signed [CoordW-1:0] in_coord_y,
  input  logic                     in_strip_begin,
  input  logic signed [WidthW-1:0] in_advance_width,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] out_vertex_x,
  output logic signed [CoordW-1:0] out_vertex_y,
  output logic                     out_strip_start,
  output logic                     out_saturated,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  cfg_t      cfg;
  logic      q_valid;
  fq_entry_t q_entry;
  logic      q_pop;

  stvg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stvg_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_strip_begin   (in_strip_begin),
    .in_advance_width (in_advance_width),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop)
  );

  stvg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_strip_start (out_strip_start),
    .out_saturated   (out_saturated)
  );

endmodule

>>> tb/sv/tb_stroke_text_vertex_generator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for stroke_text_vertex_generator_core: scoreboard and stimulus.
module tb_stroke_text_vertex_generator_core;
  import stvg_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] PATH_RIGHT  = 2'd0;
  localparam logic [1:0] PATH_LEFT   = 2'd1;
  localparam logic [1:0] PATH_UP     = 2'd2;
  localparam logic [1:0] PATH_DOWN   = 2'd3;
  localparam logic [1:0] MODE_STROKE = 2'd2;
  localparam logic [1:0] MODE_ALT    = 2'd3;

  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 200;
  localparam int STEADY_PHASE   = 4;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 32;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic signed [CoordW-1:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] MIN32 = 32'sh8000_0000;

  typedef logic signed [127:0] wide_t;

  localparam wide_t COORD_HI = 128'sd2147483647;
  localparam wide_t COORD_LO = -128'sd2147483648;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     strip;
    logic                     sat;
  } vertex_t;

  class placed_vertex_board;
    cfg_t                     regs;
    logic signed [CoordW-1:0] pen_x;
    logic signed [CoordW-1:0] pen_y;
    vertex_t                  due_q[$];
    int                       errors;

    function new();
      regs.char_height    = RST_CHAR_HEIGHT;
      regs.char_expansion = RST_CHAR_EXPANSION;
      regs.char_spacing   = RST_CHAR_SPACING;
      regs.up_vector_x    = RST_UP_VECTOR_X;
      regs.up_vector_y    = RST_UP_VECTOR_Y;
      regs.path_direction = RST_PATH_DIRECTION;
      regs.precision_mode = RST_PRECISION_MODE;
      regs.font_height    = RST_FONT_HEIGHT;
      pen_x  = '0;
      pen_y  = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [DataW-1:0] data);
      case (idx)
        REG_CHAR_HEIGHT:    regs.char_height    = data[15:0];
        REG_CHAR_EXPANSION: regs.char_expansion = data[15:0];
        REG_CHAR_SPACING:   regs.char_spacing   = data[15:0];
        REG_UP_VECTOR_X:    regs.up_vector_x    = data[15:0];
        REG_UP_VECTOR_Y:    regs.up_vector_y    = data[15:0];
        REG_PATH_DIRECTION: regs.path_direction = data[1:0];
        REG_PRECISION_MODE: regs.precision_mode = data[1:0];
        REG_FONT_HEIGHT:    regs.font_height    = data[15:0];
        default: ;
      endcase
    endfunction

    // drop sh fraction bits, rounding half up
    function wide_t drop_bits(input wide_t v, input int sh);
      return (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function logic signed [CoordW-1:0] clamp(input wide_t v, inout logic hit);
      if (v > COORD_HI) begin
        hit = 1'b1;
        return MAX32;
      end
      if (v < COORD_LO) begin
        hit = 1'b1;
        return MIN32;
      end
      return v[CoordW-1:0];
    endfunction

    function void take_item(input logic [1:0] op, input logic signed [CoordW-1:0] cx,
                            input logic signed [CoordW-1:0] cy, input logic strip,
                            input logic signed [WidthW-1:0] width);
      wide_t   h, e, s, ux, uy, fh, fx, fy, vx, vy, d, dx, dy;
      logic    stroke, hit;
      vertex_t v;
      h      = wide_t'(regs.char_height);
      e      = wide_t'(regs.char_expansion);
      s      = wide_t'($signed(regs.char_spacing));
      ux     = wide_t'($signed(regs.up_vector_x));
      uy     = wide_t'($signed(regs.up_vector_y));
      fh     = wide_t'(regs.font_height);
      stroke = regs.precision_mode > MODE_CHAR;
      hit    = 1'b0;
      case (op)
        OP_START: begin
          pen_x = cx;
          pen_y = cy;
        end
        OP_POINT: begin
          fx = drop_bits(drop_bits(wide_t'(cx) * h, 8) * e, 8);
          fy = drop_bits(wide_t'(cy) * h, 8);
          if (stroke) begin
            vx = drop_bits(fx * uy + fy * ux, 14);
            vy = drop_bits(fy * uy - fx * ux, 14);
          end else begin
            vx = fx;
            vy = fy;
          end
          v.x     = clamp(wide_t'(pen_x) + vx, hit);
          v.y     = clamp(wide_t'(pen_y) + vy, hit);
          v.strip = strip;
          v.sat   = hit;
          due_q.push_back(v);
        end
        OP_ADVANCE: begin
          dx = 0;
          dy = 0;
          if (regs.precision_mode == MODE_STRING) begin
            dx = drop_bits(wide_t'(width) * h * e, 8);
          end else if (regs.path_direction == PATH_RIGHT ||
                       regs.path_direction == PATH_LEFT) begin
            d = drop_bits((wide_t'(width) + s) * h * e, 8);
            if (stroke) begin
              dx = drop_bits(d * uy, 14);
              dy = drop_bits(-d * ux, 14);
            end else begin
              dx = d;
            end
            if (regs.path_direction == PATH_LEFT) begin
              dx = -dx;
              dy = -dy;
            end
          end else begin
            d = (fh + s) * h;
            if (stroke) begin
              dx = drop_bits(d * ux, 14);
              dy = drop_bits(d * uy, 14);
            end else begin
              dy = d;
            end
            if (regs.path_direction == PATH_DOWN) begin
              dx = -dx;
              dy = -dy;
            end
          end
          // pen saturates without a flag
          pen_x = clamp(wide_t'(pen_x) + dx, hit);
          pen_y = clamp(wide_t'(pen_y) + dy, hit);
        end
        default: ;
      endcase
    endfunction

    function void check_vertex(input logic signed [CoordW-1:0] vx,
                               input logic signed [CoordW-1:0] vy,
                               input logic strip, input logic sat);
      vertex_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: vertex expected none got x=%0d y=%0d", $time, vx, vy);
        return;
      end
      want = due_q.pop_front();
      if (want.x !== vx) begin
        errors++;
        $display("%0t: vertex_x expected %0d got %0d", $time, want.x, vx);
      end
      if (want.y !== vy) begin
        errors++;
        $display("%0t: vertex_y expected %0d got %0d", $time, want.y, vy);
      end
      if (want.strip !== strip) begin
        errors++;
        $display("%0t: strip_start expected %0b got %0b", $time, want.strip, strip);
      end
      if (want.sat !== sat) begin
        errors++;
        $display("%0t: saturated expected %0b got %0b", $time, want.sat, sat);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_opcode;
  logic signed [CoordW-1:0] in_coord_x;
  logic signed [CoordW-1:0] in_coord_y;
  logic                     in_strip_begin;
  logic signed [WidthW-1:0] in_advance_width;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [CoordW-1:0] out_vertex_x;
  logic signed [CoordW-1:0] out_vertex_y;
  logic                     out_strip_start;
  logic                     out_saturated;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  placed_vertex_board board = new();
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;

  stroke_text_vertex_generator_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_strip_begin   (in_strip_begin),
    .in_advance_width (in_advance_width),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_strip_start  (out_strip_start),
    .out_saturated    (out_saturated),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.take_item(in_opcode, in_coord_x, in_coord_y, in_strip_begin, in_advance_width);
    if (rst_n && out_valid && out_ready)
      board.check_vertex(out_vertex_x, out_vertex_y, out_strip_start, out_saturated);
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic signed [CoordW-1:0] cx,
                           input logic signed [CoordW-1:0] cy, input logic strip,
                           input logic signed [WidthW-1:0] width);
    int gap;
    gap = (!steady && $urandom_range(99) < 26) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_coord_x       <= cx;
    in_coord_y       <= cy;
    in_strip_begin   <= strip;
    in_advance_width <= width;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, data);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_scale();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(64, 1024));
  endfunction

  function automatic logic [15:0] pick_up();
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic signed [CoordW-1:0] font_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(9, 20);
  endfunction

  function automatic logic signed [CoordW-1:0] pen_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(4, 12);
  endfunction

  function automatic logic signed [WidthW-1:0] pick_width();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return $signed(16'($urandom)) >>> $urandom_range(4, 10);
  endfunction

  task automatic load_setup(input int ph);
    logic [15:0] h, e, s, ux, uy, fh;
    logic [1:0]  path, prec;
    h    = pick_scale();
    e    = pick_scale();
    s    = 16'($urandom);
    ux   = pick_up();
    uy   = pick_up();
    path = 2'($urandom);
    prec = 2'($urandom);
    fh   = pick_scale();
    case (ph)
      0: begin
        h = 16'hFFFF; e = 16'hFFFF; s = 16'h7FFF; ux = 16'd16384; uy = 16'd16384;
        path = PATH_DOWN; prec = MODE_ALT; fh = 16'hFFFF;
      end
      1: begin
        h = '0; e = '0; s = 16'h8000; ux = -16'sd16384; uy = -16'sd16384;
        path = PATH_RIGHT; prec = MODE_STRING; fh = '0;
      end
      2: begin
        ux = '0; uy = '0; prec = MODE_STROKE;
      end
      3: begin
        path = PATH_UP; prec = MODE_CHAR;
      end
      4: begin
        path = PATH_LEFT; prec = MODE_STROKE;
      end
      default: ;
    endcase
    apb_write(REG_CHAR_HEIGHT,    {16'($urandom), h});
    apb_write(REG_CHAR_EXPANSION, {16'($urandom), e});
    apb_write(REG_CHAR_SPACING,   {16'($urandom), s});
    apb_write(REG_UP_VECTOR_X,    {16'($urandom), ux});
    apb_write(REG_UP_VECTOR_Y,    {16'($urandom), uy});
    apb_write(REG_PATH_DIRECTION, {30'($urandom), path});
    apb_write(REG_PRECISION_MODE, {30'($urandom), prec});
    apb_write(REG_FONT_HEIGHT,    {16'($urandom), fh});
  endtask

  task automatic directed_items();
    send_item(OP_POINT,   '0,    '0,    1'b1, '0);
    send_item(OP_START,   MAX32, MAX32, 1'b0, '0);
    send_item(OP_POINT,   32'sh0001_0000, 32'sh0001_0000, 1'b1, '0);
    send_item(OP_POINT,   MIN32, MIN32, 1'b0, 16'sh7FFF);
    send_item(OP_START,   MIN32, MIN32, 1'b1, 16'sh8000);
    send_item(OP_POINT,   MIN32, MAX32, 1'b1, '0);
    send_item(OP_ADVANCE, '0,    '0,    1'b0, 16'sh8000);
    send_item(OP_POINT,   '0,    '0,    1'b0, '0);
    send_item(OP_START,   '0,    '0,    1'b0, '0);
    send_item(OP_ADVANCE, MAX32, MIN32, 1'b1, 16'sh7FFF);
    send_item(OP_ADVANCE, '0,    '0,    1'b0, 16'sh7FFF);
    send_item(OP_UNUSED,  MAX32, MAX32, 1'b1, 16'sh7FFF);
    send_item(OP_POINT,   -32'sd1, -32'sd1, 1'b1, '0);
    send_item(OP_START,   MAX32, '0,    1'b0, '0);
    send_item(OP_ADVANCE, '0,    '0,    1'b0, 16'sh7FFF);
    send_item(OP_POINT,   '0,    '0,    1'b1, '0);
    send_item(OP_START,   '0,    '0,    1'b0, '0);
    send_item(OP_POINT,   32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 16'sh5555);
    send_item(OP_POINT,   32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 16'shAAAA);
    send_item(OP_ADVANCE, '0,    '0,    1'b0, 16'sh0A00);
  endtask

  task automatic run_text(input int quota);
    int         sent, chars, pts;
    logic [1:0] op;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 8) begin
        op = 2'($urandom);
        send_item(op, $urandom, $urandom, 1'($urandom), 16'($urandom));
        if (op != OP_UNUSED) sent++;
      end else begin
        send_item(OP_START, pen_coord(), pen_coord(), 1'($urandom), 16'($urandom));
        sent++;
        chars = $urandom_range(1, 4);
        repeat (chars) begin
          pts = $urandom_range(1, 5);
          for (int i = 0; i < pts; i++) begin
            send_item(OP_POINT, font_coord(), font_coord(),
                      i == 0 || $urandom_range(4) == 0, 16'($urandom));
            sent++;
          end
          send_item(OP_ADVANCE, $urandom, $urandom, 1'($urandom), pick_width());
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_START;
    in_coord_x       = '0;
    in_coord_y       = '0;
    in_strip_begin   = 1'b0;
    in_advance_width = '0;
    out_ready        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      load_setup(ph);
      steady = (ph == STEADY_PHASE);
      if (ph == PRESSURE_PHASE) hold_left = HOLD_CYCLES;
      run_text(PHASE_ITEMS);
    end
    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
